/* sv/tcdab_pkg.sv */
`default_nettype none
package tcdab_pkg;

   localparam int DIST_W    = 12;
   localparam int NUM_LANES = 3;
   localparam int ZMASK_W   = 3;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 40;

   localparam int LANE_LEFT   = 0;
   localparam int LANE_RIGHT  = 1;
   localparam int LANE_MIDDLE = 2;

   localparam logic [DIST_W-1:0] EMERG_RESET = 12'd30;

   typedef logic [DIST_W-1:0] dist_type;

   // Per-request strobes shared by all lanes
   typedef struct packed {
      logic accept;
      logic first;
      logic use_seed;
      logic s1_adv;
      logic s2_adv;
   } lane_ctrl_type;

endpackage
`default_nettype wire

/* sv/tcdab_ram.sv */
`default_nettype none
module tcdab_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // Read returns the old contents when the same address is written
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem_ff[addr];
      end
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

/* sv/tcdab_lane.sv */
`default_nettype none
module tcdab_lane #(
   parameter int WINDOW_LEN  = 8,
   parameter int SAMPLE_BITS = 12,
   localparam int ADDR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tcdab_pkg::lane_ctrl_type ctrl,
   input  wire logic [ADDR_W-1:0]        slot,
   input  wire tcdab_pkg::dist_type      sample_in,
   output tcdab_pkg::dist_type           mean,
   output logic                          zero
);

   localparam int RING_W  = (SAMPLE_BITS < tcdab_pkg::DIST_W) ? SAMPLE_BITS
                                                              : tcdab_pkg::DIST_W;
   localparam int LOG_W   = $clog2(WINDOW_LEN);
   localparam int SUM_W   = RING_W + LOG_W;
   localparam int SHIFT   = SUM_W + LOG_W;
   localparam int MAGIC_W = SHIFT + 1;
   localparam int PROD_W  = SUM_W + MAGIC_W;
   // ceil(2^SHIFT / WINDOW_LEN): exact quotient for every sum that fits SUM_W
   localparam longint MAGIC_L = ((longint'(1) << SHIFT) + longint'(WINDOW_LEN) - 1)
                                / longint'(WINDOW_LEN);
   localparam logic [MAGIC_W-1:0] MAGIC = MAGIC_W'(MAGIC_L);

   logic [RING_W-1:0] samp;
   logic [RING_W-1:0] ram_rd;
   logic [RING_W-1:0] old_samp;
   logic [RING_W-1:0] seed_ff;
   logic [RING_W-1:0] samp_s1_ff;
   logic              zero_s1_ff;
   logic              first_s1_ff;
   logic              seed_sel_s1_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic              zero_s2_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic              zero_s3_ff;

   assign samp = sample_in[RING_W-1:0];

   tcdab_ram #(
      .WIDTH (RING_W),
      .DEPTH (WINDOW_LEN)
   ) u_ring (
      .clock   (clock),
      .rd_en   (ctrl.accept),
      .wr_en   (ctrl.accept),
      .addr    (slot),
      .wr_data (samp),
      .rd_data (ram_rd)
   );

   // Slots not yet rewritten since the first request still hold its sample
   assign old_samp = seed_sel_s1_ff ? seed_ff : ram_rd;

   always_comb begin
      if (first_s1_ff) begin
         sum_in = SUM_W'(samp_s1_ff) * SUM_W'(WINDOW_LEN);
      end else begin
         sum_in = sum_ff - SUM_W'(old_samp) + SUM_W'(samp_s1_ff);
      end
   end

   assign prod_in = {{MAGIC_W{1'b0}}, sum_ff} * {{SUM_W{1'b0}}, MAGIC};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.s1_adv) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         samp_s1_ff     <= samp;
         zero_s1_ff     <= (samp == '0);
         first_s1_ff    <= ctrl.first;
         seed_sel_s1_ff <= ctrl.use_seed;
         if (ctrl.first) begin
            seed_ff <= samp;
         end
      end
      if (ctrl.s1_adv) begin
         zero_s2_ff <= zero_s1_ff;
      end
      if (ctrl.s2_adv) begin
         prod_ff    <= prod_in;
         zero_s3_ff <= zero_s2_ff;
      end
   end

   assign mean = tcdab_pkg::dist_type'(prod_ff[SHIFT +: RING_W]);
   assign zero = zero_s3_ff;

endmodule
`default_nettype wire

/* sv/tcdab_merge.sv */
`default_nettype none
module tcdab_merge (
   input  wire tcdab_pkg::dist_type [tcdab_pkg::NUM_LANES-1:0] mean_vec,
   input  wire logic [tcdab_pkg::NUM_LANES-1:0]                zero_vec,
   input  wire tcdab_pkg::dist_type                            emerg_dist,
   output logic [tcdab_pkg::RSP_W-1:0]                         rsp_word
);

   logic [tcdab_pkg::NUM_LANES-1:0] below;
   logic                            brake;

   always_comb begin
      for (int i = 0; i < tcdab_pkg::NUM_LANES; i++) begin
         below[i] = (mean_vec[i] < emerg_dist);
      end
   end

   assign brake    = |below;
   assign rsp_word = {zero_vec, brake, mean_vec};

endmodule
`default_nettype wire

/* sv/three_channel_distance_average_brake.sv */
// Three-channel distance averager with emergency brake request.
//
// Request channel (req_*): one request carries a distance sample for the
// left, right and middle sensor. Result channel (rsp_*): one result per
// request with each channel's truncated mean over its last WINDOW_LEN
// samples, a brake flag (any mean below emergency_distance) and a mask of
// channels whose new sample was zero. csr_wen/csr_wdata write
// emergency_distance; write it only while no request is in flight.
//
// Throughput: one request per cycle while the result channel does not stall,
// set by the running-sum update in each lane. A result passes the ring read,
// sum update, reciprocal multiply and merge stages, in that order.
//
// Reset clears the pipeline, the write slot and the sums and sets
// emergency_distance to 30; the first request afterwards seeds the whole
// window with its samples, so its means equal the samples.
// When the receiver stalls, the pipeline keeps filling behind the output
// register; req_tready drops only once all four stages hold results.
`default_nettype none
module three_channel_distance_average_brake #(
   parameter int WINDOW_LEN  = 8,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [11:0] dist_left, [23:12] dist_right, [35:24] dist_middle, [39:36] zero
   input  wire logic [tcdab_pkg::REQ_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [11:0] mean_left, [23:12] mean_right, [35:24] mean_middle,
   // [36] brake_request, [39:37] zero_mask
   output logic [tcdab_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                          csr_wen,
   input  wire logic [tcdab_pkg::DIST_W-1:0]  csr_wdata
);

   localparam int ADDR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_LEN - 1);

   logic                          accept;
   logic                          s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic                          s1_v_in, s2_v_in, s3_v_in, out_v_in;
   logic                          out_free, s3_free, s2_free, s1_free;
   logic                          s1_adv, s2_adv, s3_adv;
   logic [ADDR_W-1:0]             slot_ff, slot_in;
   logic                          primed_ff, primed_in;
   logic                          wrapped_ff, wrapped_in;
   tcdab_pkg::dist_type           emerg_ff;
   tcdab_pkg::lane_ctrl_type      ctrl;
   tcdab_pkg::dist_type [tcdab_pkg::NUM_LANES-1:0] samples;
   tcdab_pkg::dist_type [tcdab_pkg::NUM_LANES-1:0] means;
   logic [tcdab_pkg::NUM_LANES-1:0]                zeros;
   logic [tcdab_pkg::RSP_W-1:0]   rsp_word;
   logic [tcdab_pkg::RSP_W-1:0]   rsp_data_ff;

   // Each stage moves on when the one after it is empty or moving
   assign out_free = !out_v_ff || rsp_tready;
   assign s3_adv   = s3_v_ff && out_free;
   assign s3_free  = !s3_v_ff || out_free;
   assign s2_adv   = s2_v_ff && s3_free;
   assign s2_free  = !s2_v_ff || s3_free;
   assign s1_adv   = s1_v_ff && s2_free;
   assign s1_free  = !s1_v_ff || s2_free;

   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_v_in    = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);
      s2_v_in    = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_ff);
      s3_v_in    = s2_adv ? 1'b1 : (s3_adv ? 1'b0 : s3_v_ff);
      out_v_in   = s3_adv ? 1'b1 : (rsp_tready ? 1'b0 : out_v_ff);
      slot_in    = slot_ff;
      primed_in  = primed_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         slot_in    = (slot_ff == LAST_SLOT) ? '0 : slot_ff + ADDR_W'(1);
         primed_in  = 1'b1;
         wrapped_in = wrapped_ff || (slot_ff == LAST_SLOT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
         slot_ff    <= '0;
         primed_ff  <= 1'b0;
         wrapped_ff <= 1'b0;
         emerg_ff   <= tcdab_pkg::EMERG_RESET;
      end else begin
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s2_v_in;
         s3_v_ff    <= s3_v_in;
         out_v_ff   <= out_v_in;
         slot_ff    <= slot_in;
         primed_ff  <= primed_in;
         wrapped_ff <= wrapped_in;
         if (csr_wen) begin
            emerg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         rsp_data_ff <= rsp_word;
      end
   end

   assign ctrl.accept   = accept;
   assign ctrl.first    = !primed_ff;
   assign ctrl.use_seed = !wrapped_ff;
   assign ctrl.s1_adv   = s1_adv;
   assign ctrl.s2_adv   = s2_adv;

   assign samples[tcdab_pkg::LANE_LEFT]   = req_tdata[11:0];
   assign samples[tcdab_pkg::LANE_RIGHT]  = req_tdata[23:12];
   assign samples[tcdab_pkg::LANE_MIDDLE] = req_tdata[35:24];

   for (genvar g = 0; g < tcdab_pkg::NUM_LANES; g++) begin : g_lane
      tcdab_lane #(
         .WINDOW_LEN  (WINDOW_LEN),
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .slot      (slot_ff),
         .sample_in (samples[g]),
         .mean      (means[g]),
         .zero      (zeros[g])
      );
   end

   tcdab_merge u_merge (
      .mean_vec   (means),
      .zero_vec   (zeros),
      .emerg_dist (emerg_ff),
      .rsp_word   (rsp_word)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

/* sv/tcdab_checker.sv */
`default_nettype none
module tcdab_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [tcdab_pkg::REQ_W-1:0]   req_tdata,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [tcdab_pkg::RSP_W-1:0]   rsp_tdata,
   input wire logic                          csr_wen,
   input wire logic [tcdab_pkg::DIST_W-1:0]  csr_wdata
);

   tcdab_pkg::dist_type emerg_ff;
   logic                brake_calc;

   // Track the threshold as seen on the register port
   always_ff @(posedge clock) begin
      if (reset) begin
         emerg_ff <= tcdab_pkg::EMERG_RESET;
      end else if (csr_wen) begin
         emerg_ff <= csr_wdata;
      end
   end

   assign brake_calc = (rsp_tdata[11:0] < emerg_ff) || (rsp_tdata[23:12] < emerg_ff) ||
                       (rsp_tdata[35:24] < emerg_ff);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented straight after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with an empty output stage");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request dropped or changed while waiting");

   a_brake_exact: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36] == brake_calc)
      else $error("brake flag disagrees with the reported means");

endmodule

bind three_channel_distance_average_brake tcdab_checker u_tcdab_checker (.*);
`default_nettype wire

/* test/three_channel_distance_average_brake_test.sv */
`timescale 1ns / 100ps

module three_channel_distance_average_brake_test;

   localparam int WINDOW       = 8;
   localparam int SUM_W        = 15;
   localparam int PHASE_ITEMS  = 280;
   localparam int RANDOM_PHASE = 4;
   localparam int PRINT_CAP    = 100;

   // Matches the rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [tcdab_pkg::ZMASK_W-1:0] zero_mask;
      logic                          brake;
      tcdab_pkg::dist_type           mean_middle;
      tcdab_pkg::dist_type           mean_right;
      tcdab_pkg::dist_type           mean_left;
   } avg_result_type;

   typedef struct packed {
      tcdab_pkg::dist_type           left, right, middle;
      logic                          fixed;
      tcdab_pkg::dist_type           want_left, want_right, want_middle;
      logic                          want_brake;
      logic [tcdab_pkg::ZMASK_W-1:0] want_zero;
   } probe_row_type;

   // Rows with fixed clear are checked against the running prediction
   localparam probe_row_type PROBES [23] = '{
      '{12'd0,    12'd4095, 12'd29,   1'b1, 12'd0,    12'd4095, 12'd29,   1'b1, 3'b001},
      '{12'd0,    12'd4095, 12'd29,   1'b1, 12'd0,    12'd4095, 12'd29,   1'b1, 3'b001},
      '{12'd0,    12'd4095, 12'd29,   1'b1, 12'd0,    12'd4095, 12'd29,   1'b1, 3'b001},
      '{12'd4095, 12'd0,    12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd4095, 12'd0,    12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd4095, 12'd0,    12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd4095, 12'd0,    12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd4095, 12'd0,    12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd4095, 12'd0,    12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd4095, 12'd0,    12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd4095, 12'd0,    12'd30,   1'b1, 12'd4095, 12'd0,    12'd30,   1'b1, 3'b010},
      '{12'd30,   12'd30,   12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd30,   12'd30,   12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd30,   12'd30,   12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd30,   12'd30,   12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd30,   12'd30,   12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd30,   12'd30,   12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd30,   12'd30,   12'd30,   1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd30,   12'd30,   12'd30,   1'b1, 12'd30,   12'd30,   12'd30,   1'b0, 3'b000},
      '{12'd0,    12'd0,    12'd0,    1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd4095, 12'd4095, 12'd4095, 1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd1,    12'd2048, 12'd4094, 1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000},
      '{12'd2730, 12'd1365, 12'd0,    1'b0, 12'd0,    12'd0,    12'd0,    1'b0, 3'b000}
   };

   localparam tcdab_pkg::dist_type PHASE_LIMITS [6] =
      '{12'd0, 12'd4095, 12'd1, 12'd2048, 12'd0, 12'd30};

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [tcdab_pkg::REQ_W-1:0]    req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [tcdab_pkg::RSP_W-1:0]    rsp_tdata;
   logic                           csr_wen    = 1'b0;
   logic [tcdab_pkg::DIST_W-1:0]   csr_wdata  = '0;

   // Predicted window state
   tcdab_pkg::dist_type echo_ring [tcdab_pkg::NUM_LANES][WINDOW];
   logic [SUM_W-1:0]    echo_sum [tcdab_pkg::NUM_LANES];
   logic [2:0]          echo_slot   = '0;
   bit                  echo_primed = 1'b0;
   tcdab_pkg::dist_type brake_limit = tcdab_pkg::EMERG_RESET;

   avg_result_type pending_means [$];
   int             fail_count  = 0;
   int             print_count = 0;
   bit             calm        = 1'b0;

   three_channel_distance_average_brake DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [tcdab_pkg::RSP_W-1:0] got,
                                  want);
      fail_count++;
      if (print_count < PRINT_CAP) begin
         print_count++;
         $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   task automatic average_samples(input tcdab_pkg::dist_type l, r, m,
                                  output avg_result_type res);
      tcdab_pkg::dist_type sample [tcdab_pkg::NUM_LANES];
      tcdab_pkg::dist_type mean [tcdab_pkg::NUM_LANES];
      sample[tcdab_pkg::LANE_LEFT]   = l;
      sample[tcdab_pkg::LANE_RIGHT]  = r;
      sample[tcdab_pkg::LANE_MIDDLE] = m;
      for (int lane = 0; lane < tcdab_pkg::NUM_LANES; lane++) begin
         if (!echo_primed) begin
            // first request after reset fills the whole window
            for (int k = 0; k < WINDOW; k++)
               echo_ring[lane][k] = sample[lane];
            echo_sum[lane] = SUM_W'(SUM_W'(sample[lane]) * SUM_W'(WINDOW));
         end else begin
            echo_sum[lane] = echo_sum[lane] - SUM_W'(echo_ring[lane][echo_slot])
                             + SUM_W'(sample[lane]);
            echo_ring[lane][echo_slot] = sample[lane];
         end
         mean[lane] = tcdab_pkg::dist_type'(echo_sum[lane] / WINDOW);
      end
      echo_primed = 1'b1;
      // three bits wrap at the window length
      echo_slot = echo_slot + 1'b1;
      res.mean_left   = mean[tcdab_pkg::LANE_LEFT];
      res.mean_right  = mean[tcdab_pkg::LANE_RIGHT];
      res.mean_middle = mean[tcdab_pkg::LANE_MIDDLE];
      res.brake       = (mean[tcdab_pkg::LANE_LEFT] < brake_limit)
                        || (mean[tcdab_pkg::LANE_RIGHT] < brake_limit)
                        || (mean[tcdab_pkg::LANE_MIDDLE] < brake_limit);
      res.zero_mask   = {m == '0, r == '0, l == '0};
   endtask

   task automatic send_request(input tcdab_pkg::dist_type l, r, m, input bit fixed,
                               input avg_result_type typed_want);
      avg_result_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= tcdab_pkg::REQ_W'({m, r, l});
      do @(posedge clock); while (!req_tready);
      average_samples(l, r, m, predicted);
      pending_means.push_back(fixed ? typed_want : predicted);
   endtask

   task automatic pause_sender();
      req_tvalid <= 1'b0;
      req_tdata  <= tcdab_pkg::REQ_W'({tcdab_pkg::dist_type'($urandom),
                                       tcdab_pkg::dist_type'($urandom),
                                       tcdab_pkg::dist_type'($urandom)});
      repeat ($urandom_range(1, 10)) @(posedge clock);
   endtask

   task automatic write_limit(input tcdab_pkg::dist_type value);
      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      // let the pipeline settle before touching the threshold
      repeat (6) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      brake_limit = value;
   endtask

   // Hugging keeps samples close to the threshold so the means straddle it
   function automatic tcdab_pkg::dist_type pick_distance(input bit hug);
      int near;
      if (hug && $urandom_range(0, 4) != 0) begin
         near = int'(brake_limit) + int'($urandom_range(0, 6)) - 3;
         if (near < 0)
            near = 0;
         if (near > 4095)
            near = 4095;
         return tcdab_pkg::dist_type'(near);
      end
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return tcdab_pkg::dist_type'($urandom_range(1, 63));
         default: return tcdab_pkg::dist_type'($urandom);
      endcase
   endfunction

   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      avg_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = avg_result_type'(rsp_tdata);
         if (pending_means.size() == 0) begin
            report_mismatch("unexpected result", got, '0);
         end else begin
            want = pending_means.pop_front();
            if (got.mean_left !== want.mean_left)
               report_mismatch("mean_left", got.mean_left, want.mean_left);
            if (got.mean_right !== want.mean_right)
               report_mismatch("mean_right", got.mean_right, want.mean_right);
            if (got.mean_middle !== want.mean_middle)
               report_mismatch("mean_middle", got.mean_middle, want.mean_middle);
            if (got.brake !== want.brake)
               report_mismatch("brake_request", got.brake, want.brake);
            if (got.zero_mask !== want.zero_mask)
               report_mismatch("zero_mask", got.zero_mask, want.zero_mask);
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(PROBES); i++) begin
         avg_result_type typed_want;
         typed_want.mean_left   = PROBES[i].want_left;
         typed_want.mean_right  = PROBES[i].want_right;
         typed_want.mean_middle = PROBES[i].want_middle;
         typed_want.brake       = PROBES[i].want_brake;
         typed_want.zero_mask   = PROBES[i].want_zero;
         if ($urandom_range(0, 4) == 0)
            pause_sender();
         send_request(PROBES[i].left, PROBES[i].right, PROBES[i].middle, PROBES[i].fixed,
                      typed_want);
      end

      for (int phase = 0; phase < $size(PHASE_LIMITS); phase++) begin
         tcdab_pkg::dist_type next_limit;
         bit                  hug;
         next_limit = (phase == RANDOM_PHASE)
                      ? tcdab_pkg::dist_type'($urandom_range(2, 4094))
                      : PHASE_LIMITS[phase];
         write_limit(next_limit);
         calm = (phase == $size(PHASE_LIMITS) - 1);
         hug  = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0)
               hug = ($urandom_range(0, 2) == 0);
            if (!calm && $urandom_range(0, 5) == 0)
               pause_sender();
            send_request(pick_distance(hug), pick_distance(hug), pick_distance(hug), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
